// ----- src/sll_pkg.sv -----
package sll_pkg;

  localparam int MAX_NODES = 64;
  localparam int SLOT_W = $clog2(MAX_NODES + 1);
  localparam int POS_W = 7;
  localparam int CAP_W = 7;
  localparam int DATA_W = 32;
  localparam int CMP_W = (SLOT_W > POS_W) ? SLOT_W : POS_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_LINK,
    ST_LINK2,
    ST_FETCH,
    ST_TAKE,
    ST_DONE
  } state_t;

endpackage

// ----- src/sll_front.sv -----
module sll_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [1:0]             opcode,
  input  logic [sll_pkg::POS_W-1:0]  position,
  input  logic [sll_pkg::DATA_W-1:0] value,
  output logic                   q_valid,
  input  logic                   q_ready,
  output sll_pkg::req_t          q_req
);
  import sll_pkg::*;

  logic held;
  req_t req;
  op_t  op_dec;

  always_comb begin
    case (opcode)
      OP_INSERT: op_dec = OP_INSERT;
      OP_GET:    op_dec = OP_GET;
      OP_DELETE: op_dec = OP_DELETE;
      default:   op_dec = OP_CLEAR;
    endcase
  end

  assign req_ready = !held || q_ready;
  assign q_valid   = held;
  assign q_req     = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (req_ready) begin
      held <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req.op       <= op_dec;
      req.position <= position;
      req.value    <= value;
    end
  end

endmodule

// ----- src/sll_queue.sv -----
module sll_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sll_pkg::req_t wr_req,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sll_pkg::req_t rd_req
);
  import sll_pkg::*;

  req_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign wr_ready = fill != QCNT_W'(QDEPTH);
  assign rd_valid = fill != '0;
  assign rd_req   = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_req;
    end
  end

endmodule

// ----- src/sll_back.sv -----
module sll_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sll_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  sll_pkg::req_t              q_req,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       ok,
  output logic [sll_pkg::DATA_W-1:0] value_out,
  output logic [sll_pkg::POS_W-1:0]  length
);
  import sll_pkg::*;

  state_t            state, state_next;
  logic [CAP_W-1:0]  capacity;
  op_t               op, op_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [DATA_W-1:0] val, val_next;
  slot_t             cur, cur_next;
  slot_t             step, step_next;
  slot_t             scan, scan_next;
  slot_t             slot, slot_next;
  slot_t             obj, obj_next;
  slot_t             head, head_next;
  slot_t             count, count_next;
  logic [MAX_NODES:1] free_map, free_map_next;
  logic              res_ok, res_ok_next;
  logic [DATA_W-1:0] res_val, res_val_next;
  logic              res_valid_next;
  logic              ok_next;
  logic [DATA_W-1:0] value_out_next;
  logic [POS_W-1:0]  length_next;

  slot_t             link_mem [0:MAX_NODES];
  logic [DATA_W-1:0] data_mem [0:MAX_NODES];
  slot_t             link_rd;
  logic [DATA_W-1:0] data_rd;
  logic              lw_en;
  slot_t             lw_addr;
  slot_t             lw_data;
  slot_t             lr_addr;
  logic              dw_en;
  slot_t             dr_addr;

  logic [CMP_W-1:0]  cap_c;
  logic [CMP_W-1:0]  count_c;
  slot_t             cur_link;
  logic              advance;
  logic              out_free;

  assign cap_c = (CMP_W'(capacity) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES)
                                                        : CMP_W'(capacity);
  assign count_c  = CMP_W'(count);
  assign cur_link = (cur == '0) ? head : link_rd;
  assign advance  = (CMP_W'(step) < CMP_W'(pos)) && (step < slot_t'(MAX_NODES))
                    && (cur_link != '0);
  assign out_free = !res_valid || res_ready;
  assign q_ready  = state == ST_IDLE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_req.op)
            OP_INSERT: state_next = (count_c < cap_c) ? ST_SCAN : ST_DONE;
            OP_GET, OP_DELETE: begin
              state_next = (CMP_W'(q_req.position) < count_c) ? ST_WALK : ST_DONE;
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (free_map[scan]) begin
          state_next = ST_WALK;
        end else if (CMP_W'(scan) >= cap_c) begin
          state_next = ST_DONE;
        end
      end
      ST_WALK: begin
        if (!advance) begin
          state_next = (op == OP_INSERT) ? ST_LINK : ST_FETCH;
        end
      end
      ST_LINK:  state_next = (cur == '0) ? ST_DONE : ST_LINK2;
      ST_LINK2: state_next = ST_DONE;
      ST_FETCH: state_next = ST_TAKE;
      ST_TAKE:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_next        = op;
    pos_next       = pos;
    val_next       = val;
    cur_next       = cur;
    step_next      = step;
    scan_next      = scan;
    slot_next      = slot;
    obj_next       = obj;
    head_next      = head;
    count_next     = count;
    free_map_next  = free_map;
    res_ok_next    = res_ok;
    res_val_next   = res_val;
    res_valid_next = res_valid && !res_ready;
    ok_next        = ok;
    value_out_next = value_out;
    length_next    = length;
    lw_en          = 1'b0;
    lw_addr        = slot;
    lw_data        = cur_link;
    lr_addr        = cur;
    dw_en          = 1'b0;
    dr_addr        = obj;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          op_next      = q_req.op;
          pos_next     = q_req.position;
          val_next     = q_req.value;
          cur_next     = '0;
          step_next    = '0;
          scan_next    = slot_t'(1);
          res_ok_next  = 1'b0;
          res_val_next = '0;
          if (q_req.op == OP_CLEAR) begin
            head_next     = '0;
            count_next    = '0;
            free_map_next = '1;
            res_ok_next   = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (free_map[scan]) begin
          slot_next = scan;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      ST_WALK: begin
        if (advance) begin
          cur_next  = cur_link;
          step_next = step + 1'b1;
          lr_addr   = cur_link;
        end else begin
          obj_next = cur_link;
        end
      end
      ST_LINK: begin
        lw_en   = 1'b1;
        lw_addr = slot;
        lw_data = cur_link;
        dw_en   = 1'b1;
        free_map_next[slot] = 1'b0;
        count_next  = count + 1'b1;
        res_ok_next = 1'b1;
        if (cur == '0) begin
          head_next = slot;
        end
      end
      ST_LINK2: begin
        lw_en   = 1'b1;
        lw_addr = cur;
        lw_data = slot;
      end
      ST_FETCH: begin
        lr_addr = obj;
      end
      ST_TAKE: begin
        res_ok_next  = 1'b1;
        res_val_next = data_rd;
        if (op == OP_DELETE && obj != '0) begin
          free_map_next[obj] = 1'b1;
          count_next = count - 1'b1;
          if (cur == '0) begin
            head_next = link_rd;
          end else begin
            lw_en   = 1'b1;
            lw_addr = cur;
            lw_data = link_rd;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          res_valid_next = 1'b1;
          ok_next        = res_ok;
          value_out_next = res_val;
          length_next    = POS_W'(count);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= CAP_RESET;
      head      <= '0;
      count     <= '0;
      free_map  <= '1;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      free_map  <= free_map_next;
      res_valid <= res_valid_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op        <= op_next;
    pos       <= pos_next;
    val       <= val_next;
    cur       <= cur_next;
    step      <= step_next;
    scan      <= scan_next;
    slot      <= slot_next;
    obj       <= obj_next;
    res_ok    <= res_ok_next;
    res_val   <= res_val_next;
    ok        <= ok_next;
    value_out <= value_out_next;
    length    <= length_next;
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    link_rd <= link_mem[lr_addr];
  end

  always_ff @(posedge clk) begin
    if (dw_en) begin
      data_mem[slot] <= val;
    end
    data_rd <= data_mem[dr_addr];
  end

endmodule

// ----- src/static_linked_list_engine.sv -----
// Linked list of up to 64 data words kept in slot memories. A request enters through a
// register and a two-entry queue, and the executor takes one request at a time. Clear
// empties the list; get and delete walk to the position and fetch the node; insert
// finds the lowest free slot, walks to min(position, length) and writes the node, with
// a second link write when not at the head. The free-slot scan checks one slot a cycle
// and the walk follows one link a cycle through the single read port of the link memory.
// The next request can wait in the queue while a result waits on res_ready.
module static_linked_list_engine (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [sll_pkg::CAP_W-1:0]  cfg_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  logic [1:0]                 opcode,
  input  logic [sll_pkg::POS_W-1:0]  position,
  input  logic [sll_pkg::DATA_W-1:0] value,
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic                       ok,
  output logic [sll_pkg::DATA_W-1:0] value_out,
  output logic [sll_pkg::POS_W-1:0]  length
);
  import sll_pkg::*;

  logic f_valid;
  logic f_ready;
  req_t f_req;
  logic b_valid;
  logic b_ready;
  req_t b_req;

  sll_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .opcode    (opcode),
    .position  (position),
    .value     (value),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_req     (f_req)
  );

  sll_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_req   (f_req),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_req   (b_req)
  );

  sll_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_req     (b_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .ok        (ok),
    .value_out (value_out),
    .length    (length)
  );

endmodule
